### rtl/core/vcra_pkg.sv
package vcra_pkg;

	localparam int MAX_SLOTS      = 16;
	localparam int MAX_AREA_BYTES = 4096;

	localparam int SLOT_W   = $clog2(MAX_SLOTS);
	localparam int NSLOTS_W = $clog2(MAX_SLOTS + 1);
	localparam int OFF_W    = 12;
	localparam int LEN_W    = 13;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_PEEK  = 2'd1;
	localparam logic [1:0] OP_REF   = 2'd2;
	localparam logic [1:0] OP_COPY  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_NO_SLOT  = 3'd2;
	localparam logic [2:0] ST_NO_SPACE = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN = 3'd4;
	localparam logic [2:0] ST_CAPACITY = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_BYTES   = 1'b1;

	typedef struct packed {
		logic [1:0]       operation;
		logic [LEN_W-1:0] chunk_length;
		logic [LEN_W-1:0] out_capacity;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [SLOT_W-1:0] unread_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic launch;
		logic exec;
	} ctrl_cmd_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
			input logic [NSLOTS_W-1:0] n);
		logic [NSLOTS_W-1:0] inc;
		inc = NSLOTS_W'(s) + NSLOTS_W'(1);
		return (inc >= n) ? '0 : inc[SLOT_W-1:0];
	endfunction

endpackage

### rtl/core/vcra_ctrl.sv
module vcra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output vcra_pkg::ctrl_cmd_t  ctrl
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy        = (state_q == S_EXEC);
	assign done        = done_q;
	assign ctrl.launch = start && (state_q == S_IDLE);
	assign ctrl.exec   = (state_q == S_EXEC);

endmodule

### rtl/core/vcra_dp.sv
module vcra_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vcra_pkg::ctrl_cmd_t                 ctrl,
	input  vcra_pkg::cmd_t                      cmd,
	input  logic                                cfg_we,
	input  logic [vcra_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vcra_pkg::CFG_W-1:0]          cfg_data,
	output vcra_pkg::result_t                   result
);

	localparam int SW  = vcra_pkg::SLOT_W;
	localparam int NW  = vcra_pkg::NSLOTS_W;
	localparam int OW  = vcra_pkg::OFF_W;
	localparam int LW  = vcra_pkg::LEN_W;

	logic [NW-1:0] slots_q;
	logic [LW-1:0] area_q;
	logic [SW-1:0] rs_q, ws_q, count_q;
	// Offset at which the next chunk would go; the table entry at the write slot
	// is never read, so this register stands in for it.
	logic [OW-1:0] wo_q;

	logic [OW-1:0] off_mem [vcra_pkg::MAX_SLOTS];
	logic [LW-1:0] len_mem [vcra_pkg::MAX_SLOTS];

	vcra_pkg::cmd_t  cmd_s1;
	logic [OW-1:0]   rd_off_s1;
	logic [LW-1:0]   rd_len_s1;
	vcra_pkg::result_t result_q;

	logic          empty, full, wr_ok, pop;
	logic [OW-1:0] ro, place;
	logic [LW-1:0] room, gap, wo_ext, ro_ext, len, end_off;
	logic [2:0]    st;
	logic [OW-1:0] res_off;
	logic [LW-1:0] res_len;
	logic [SW-1:0] count_d;
	logic [NW-1:0] cfg_slots;
	logic [LW-1:0] cfg_area;

	always_ff @(posedge clk) begin
		if (ctrl.launch) begin
			cmd_s1    <= cmd;
			rd_off_s1 <= off_mem[rs_q];
			rd_len_s1 <= len_mem[rs_q];
		end
		if (ctrl.exec && wr_ok) begin
			off_mem[ws_q] <= place;
			len_mem[ws_q] <= len;
		end
	end

	always_comb begin
		empty  = (count_q == '0);
		full   = ((NW'(count_q) + NW'(1)) == slots_q);
		ro     = empty ? wo_q : rd_off_s1;
		wo_ext = LW'(wo_q);
		ro_ext = LW'(ro);
		len    = cmd_s1.chunk_length;
		room   = (area_q > wo_ext) ? (area_q - wo_ext) : '0;
		gap    = ro_ext - wo_ext;
		wr_ok  = 1'b0;
		pop    = 1'b0;
		place  = wo_q;
		st     = vcra_pkg::ST_OK;
		res_off = '0;
		res_len = '0;
		if (cmd_s1.operation == vcra_pkg::OP_WRITE) begin
			if (len == '0) begin
				st = vcra_pkg::ST_ZERO_LEN;
			end else if (full) begin
				st = vcra_pkg::ST_NO_SLOT;
			end else if (ro <= wo_q) begin
				if (len < room) begin
					wr_ok = 1'b1;
				end else if (len < ro_ext) begin
					wr_ok = 1'b1;
					place = '0;
				end else begin
					st = vcra_pkg::ST_NO_SPACE;
				end
			end else if (len < gap) begin
				wr_ok = 1'b1;
			end else begin
				st = vcra_pkg::ST_NO_SPACE;
			end
			if (wr_ok) begin
				res_off = place;
				res_len = len;
			end
		end else if (empty) begin
			st = vcra_pkg::ST_EMPTY;
		end else begin
			res_off = rd_off_s1;
			res_len = rd_len_s1;
			if (cmd_s1.operation == vcra_pkg::OP_COPY
					&& cmd_s1.out_capacity < rd_len_s1) begin
				st = vcra_pkg::ST_CAPACITY;
			end else begin
				pop = (cmd_s1.operation != vcra_pkg::OP_PEEK);
			end
		end
		end_off = LW'(place) + len;
		count_d = count_q;
		if (wr_ok) count_d = count_q + SW'(1);
		else if (pop) count_d = count_q - SW'(1);
	end

	always_comb begin
		cfg_slots = cfg_data[NW-1:0];
		if (cfg_slots < NW'(2)) cfg_slots = NW'(2);
		if (cfg_slots > NW'(vcra_pkg::MAX_SLOTS)) cfg_slots = NW'(vcra_pkg::MAX_SLOTS);
		cfg_area = cfg_data[LW-1:0];
		if (cfg_area < LW'(1)) cfg_area = LW'(1);
		if (cfg_area > LW'(vcra_pkg::MAX_AREA_BYTES)) cfg_area = LW'(vcra_pkg::MAX_AREA_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= NW'(vcra_pkg::MAX_SLOTS);
			area_q  <= LW'(vcra_pkg::MAX_AREA_BYTES);
			rs_q    <= '0;
			ws_q    <= '0;
			count_q <= '0;
			wo_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vcra_pkg::CFG_SLOTS_IN_USE: begin
					slots_q <= cfg_slots;
				end
				vcra_pkg::CFG_AREA_BYTES: begin
					area_q <= cfg_area;
				end
				default: begin
				end
			endcase
			// Any register write starts the ring afresh.
			rs_q    <= '0;
			ws_q    <= '0;
			count_q <= '0;
			wo_q    <= '0;
		end else if (ctrl.exec) begin
			count_q <= count_d;
			if (wr_ok) begin
				ws_q <= vcra_pkg::next_slot(ws_q, slots_q);
				wo_q <= end_off[OW-1:0];
			end
			if (pop) rs_q <= vcra_pkg::next_slot(rs_q, slots_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			result_q.status       <= st;
			result_q.offset       <= res_off;
			result_q.length       <= res_len;
			result_q.unread_count <= count_d;
		end
	end

	assign result = result_q;

endmodule

### rtl/core/variable_chunk_ring_allocator.sv
// Channel   Handshake            Word
// command   start / busy         cmd (operation, chunk_length, out_capacity)
// result    done (strobe)        result (status, offset, length, unread_count)
// config    cfg_we               cfg_index, cfg_data
//
// For each command, the descriptor tables are read on the cycle that takes
// the command, and the decision and write-back happen in the next.
// The result shows for one cycle while busy is already low, so a new command
// may be taken alongside it. The receiver cannot stall the block.
// Reset clears the ring and restores both registers to their largest values.
module variable_chunk_ring_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  vcra_pkg::cmd_t                  cmd,
	output logic                            busy,
	output logic                            done,
	output vcra_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [vcra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcra_pkg::CFG_W-1:0]      cfg_data
);

	vcra_pkg::ctrl_cmd_t ctrl;

	vcra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	vcra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

### dv/chunk_ring_checker.sv
`timescale 1ns / 1ps

module chunk_ring_checker
	import vcra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  cmd_t                 cmd,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);

	logic [LEN_W-1:0] seg_start [MAX_SLOTS];
	logic [LEN_W-1:0] seg_size  [MAX_SLOTS];
	int unsigned      rd_ptr;
	int unsigned      wr_ptr;
	int unsigned      ring_slots;
	int unsigned      area_size;
	result_t          due_results [$];
	result_t          want;

	function automatic int unsigned step_slot(input int unsigned s);
		return (s + 1 >= ring_slots) ? 0 : s + 1;
	endfunction

	function automatic int unsigned chunks_unread();
		return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + ring_slots - rd_ptr;
	endfunction

	function automatic void empty_ring();
		foreach (seg_start[i]) begin
			seg_start[i] = '0;
			seg_size[i]  = '0;
		end
		rd_ptr = 0;
		wr_ptr = 0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		int unsigned v;
		if (idx == CFG_SLOTS_IN_USE) begin
			// Only the low five bits reach the slot count register.
			v = 32'(data[4:0]);
			ring_slots = (v < 2) ? 2 : (v > MAX_SLOTS) ? MAX_SLOTS : v;
		end else begin
			v = 32'(data);
			area_size = (v < 1) ? 1 : (v > MAX_AREA_BYTES) ? MAX_AREA_BYTES : v;
		end
		empty_ring();
	endfunction

	// Works out the outcome of one command and moves the ring state on.
	function automatic result_t apply_command(input cmd_t c);
		result_t     r;
		int unsigned nw;
		int unsigned ro;
		int unsigned wo;
		int unsigned room;
		int unsigned place;
		bit          fits;
		r = '0;
		place = 0;
		if (c.operation == OP_WRITE) begin
			nw = step_slot(wr_ptr);
			if (c.chunk_length == 0) begin
				r.status = ST_ZERO_LEN;
			end else if (nw == rd_ptr) begin
				r.status = ST_NO_SLOT;
			end else begin
				ro = 32'(seg_start[rd_ptr]);
				wo = 32'(seg_start[wr_ptr]);
				fits = 1'b1;
				if (ro <= wo) begin
					// Try after the newest chunk, else wrap to the start of the area.
					room = (wo < area_size) ? area_size - wo : 0;
					if (c.chunk_length < room)
						place = wo;
					else if (c.chunk_length < ro)
						place = 0;
					else
						fits = 1'b0;
				end else if (c.chunk_length < ro - wo) begin
					place = wo;
				end else begin
					fits = 1'b0;
				end
				if (!fits) begin
					r.status = ST_NO_SPACE;
				end else begin
					seg_start[wr_ptr] = LEN_W'(place);
					seg_size[wr_ptr]  = c.chunk_length;
					seg_start[nw]     = LEN_W'(place + 32'(c.chunk_length));
					wr_ptr   = nw;
					r.status = ST_OK;
					r.offset = OFF_W'(place);
					r.length = c.chunk_length;
				end
			end
		end else if (rd_ptr == wr_ptr) begin
			r.status = ST_EMPTY;
		end else begin
			r.offset = seg_start[rd_ptr][OFF_W-1:0];
			r.length = seg_size[rd_ptr];
			if (c.operation == OP_COPY && c.out_capacity < seg_size[rd_ptr]) begin
				r.status = ST_CAPACITY;
			end else begin
				r.status = ST_OK;
				if (c.operation != OP_PEEK)
					rd_ptr = step_slot(rd_ptr);
			end
		end
		r.unread_count = SLOT_W'(chunks_unread());
		return r;
	endfunction

	task automatic check_field(input string what, input int unsigned exp_val,
			input logic [LEN_W-1:0] got);
		if (got !== LEN_W'(exp_val)) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_slots = MAX_SLOTS;
			area_size  = MAX_AREA_BYTES;
			empty_ring();
			due_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					$display("%0t: result word expected none, %s %0d offset %0d length %0d",
						$time, "got status", result.status, result.offset,
						result.length);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 32'(want.status), LEN_W'(result.status));
					check_field("offset", 32'(want.offset), LEN_W'(result.offset));
					check_field("length", 32'(want.length), result.length);
					check_field("unread_count", 32'(want.unread_count),
						LEN_W'(result.unread_count));
				end
			end
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			if (start && !busy)
				due_results.push_back(apply_command(cmd));
			pending <= due_results.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import vcra_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 12;
	localparam int PHASE_WORDS = 160;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	cmd_t                 cmd       = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 done;
	result_t              result;
	int                   mismatches;
	int                   pending;
	int                   gap_pct;
	int                   ring_depth;
	int                   area_sz;
	int                   quiet_cycles;

	int slot_vals [PHASES] = '{16, 2, 0, 5, 31, 3, 17, 9, 16, 4, 12, 1};
	int area_vals [PHASES] = '{4096, 64, 8191, 300, 0, 4096, 17, 1000, 2048, 7, 4095, 150};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	variable_chunk_ring_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	chunk_ring_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= IDLE_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// Returns just after the edge that takes the word; start is left high.
	task automatic issue(input logic [1:0] op, input logic [LEN_W-1:0] len,
			input logic [LEN_W-1:0] cap);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start <= 1'b1;
		cmd   <= '{operation: op, chunk_length: len, out_capacity: cap};
		do @(posedge clk); while (busy);
	endtask

	// Registers change only once every result is back and the block has settled.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word(input int unit, input int wr_pct);
		logic [1:0]       op;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] cap;
		int               k;
		len = LEN_W'($urandom_range(0, 8191));
		cap = LEN_W'($urandom_range(0, 8191));
		if ($urandom_range(99) < wr_pct) begin
			op = OP_WRITE;
			k = $urandom_range(99);
			if (k < 4)
				len = 0;
			else if (k < 8)
				len = LEN_W'($urandom_range(area_sz, 8191));
			else if (k < 18)
				len = LEN_W'(unit);
			else if (k < 28)
				len = LEN_W'($urandom_range(1, area_sz));
			else
				len = LEN_W'($urandom_range(1, 2 * unit));
		end else begin
			op = 2'($urandom_range(1, 3));
			k = $urandom_range(99);
			if (k < 30)
				cap = LEN_W'(unit);
			else if (k < 45)
				cap = LEN_W'(unit - 1);
			else if (k < 50)
				cap = LEN_W'($urandom_range(4096, 8191));
			else
				cap = LEN_W'($urandom_range(0, 2 * unit));
		end
		issue(op, len, cap);
	endtask

	initial begin
		int unit;
		int wr_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 18;
		// Empty ring on every read kind, then the failing writes.
		issue(OP_PEEK, 0, 0);
		issue(OP_REF, 8191, 0);
		issue(OP_COPY, 0, 8191);
		issue(OP_WRITE, 0, 0);
		issue(OP_WRITE, 4096, 0);
		issue(OP_WRITE, 8191, 4096);
		// Largest chunk that fits, then the capacity check on both sides.
		issue(OP_WRITE, 4095, 0);
		issue(OP_PEEK, 0, 0);
		issue(OP_COPY, 0, 4094);
		issue(OP_COPY, 0, 4095);
		// The ring is empty again but the oldest offset sits near the end,
		// so a one-byte chunk must wrap to the start of the area.
		issue(OP_WRITE, 1, 0);
		issue(OP_WRITE, 4094, 0);
		issue(OP_WRITE, 1, 0);
		issue(OP_REF, 0, 0);
		issue(OP_REF, 0, 0);
		issue(OP_REF, 0, 0);

		set_reg(CFG_SLOTS_IN_USE, 2);
		issue(OP_WRITE, 5, 0);
		issue(OP_WRITE, 5, 0);
		issue(OP_COPY, 0, 4096);
		set_reg(CFG_AREA_BYTES, 1);
		issue(OP_WRITE, 1, 0);

		for (int p = 0; p < PHASES; p++) begin
			gap_pct = (p < 4) ? 18 : (p < 8) ? 75 : 0;
			if (p % 2 == 0) begin
				set_reg(CFG_SLOTS_IN_USE, slot_vals[p]);
				set_reg(CFG_AREA_BYTES, area_vals[p]);
			end else begin
				set_reg(CFG_AREA_BYTES, area_vals[p]);
				set_reg(CFG_SLOTS_IN_USE, slot_vals[p]);
			end
			ring_depth = slot_vals[p] % 32;
			ring_depth = (ring_depth < 2) ? 2 : (ring_depth > MAX_SLOTS) ? MAX_SLOTS : ring_depth;
			area_sz = (area_vals[p] < 1) ? 1 :
				(area_vals[p] > MAX_AREA_BYTES) ? MAX_AREA_BYTES : area_vals[p];
			// Bursts lean towards writes or reads so the ring both fills and drains.
			for (int b = 0; b < PHASE_WORDS / 20; b++) begin
				unit = area_sz / $urandom_range(2, 2 * ring_depth);
				if (unit < 1)
					unit = 1;
				wr_pct = $urandom_range(20, 85);
				repeat (20) random_word(unit, wr_pct);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
